[rtl/morm_pkg.sv]
`default_nettype none

package morm_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int MEAN_W    = 11;
  localparam int THR_W     = 10;
  localparam int STORE_N   = 8;
  localparam int IDX_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int SUM_W     = 16;
  localparam int DIVD_W    = 15;

  localparam logic signed [SAMPLE_W-1:0] TEMP_85 = 12'sd1360;

  localparam logic [THR_W-1:0]    THRESHOLD_RST  = 10'd160;
  localparam logic [SAMPLE_W-1:0] VALID_LOW_RST  = 12'd160;
  localparam logic [SAMPLE_W-1:0] VALID_HIGH_RST = 12'd960;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_VALID_LOW  = 2'd1,
    REG_VALID_HIGH = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_present;
    logic                       last_sample;
  } item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_temp;
    logic               mean_valid;
    logic [STORE_N-1:0] outlier_mask;
    logic [COUNT_W-1:0] pass_count;
  } result_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           origin;
  } entry_t;

endpackage

`default_nettype wire

[rtl/morm_div.sv]
`default_nettype none

module morm_div
  import morm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIVD_W-1:0]  dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output logic                    done,
  output logic [MEAN_W-1:0]       quotient
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0]  dq;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic [STEP_W-1:0]  steps;
  logic               running;
  logic [COUNT_W:0]   trial;
  logic               fits;

  assign trial    = {rem, dq[DIVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dq[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(DIVD_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      rem <= fits ? COUNT_W'(trial - {1'b0, dvs}) : trial[COUNT_W-1:0];
      dq  <= {dq[DIVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[rtl/median_outlier_reject_mean_core.sv]
// channel  | beat marked by            | payload
// ---------+---------------------------+-------------------------------
// reading  | start & !busy             | item (sample, present, last)
// result   | done, one cycle           | result (mean, valid, mask, count)
// config   | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// a reading without last leaves busy low, so the block can take the next reading straight after it
// a reading with last keeps busy high through the rank sweep, the outlier sweep,
// a prep step and the bit-serial divider for n >= 1 stored readings; the divider
// is skipped when no reading is left to divide or the sum is negative
// with n = 0 the result comes the next cycle
// sync reset, active high, clears control and counters, presets the config registers
// results cannot be stalled; done lasts exactly one cycle; cfg_ready is always high

`default_nettype none

module median_outlier_reject_mean_core
  import morm_pkg::*;
#(
  parameter int SENSORS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire item_t               item,
  output logic                     done,
  output result_t                  result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [SAMPLE_W-1:0] cfg_data
);

  localparam logic [COUNT_W:0] SENS_LIM = (COUNT_W + 1)'(SENSORS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RANK = 6'b000010,
    S_SCAN = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [THR_W-1:0]           threshold;
  logic signed [SAMPLE_W-1:0] valid_low;
  logic signed [SAMPLE_W-1:0] valid_high;

  logic [COUNT_W-1:0] position;
  logic [COUNT_W-1:0] kept_count;
  logic [COUNT_W-1:0] n;

  entry_t mem [STORE_N];
  entry_t rd_a;
  entry_t rd_b;

  logic [IDX_W-1:0] ri;
  logic [IDX_W-1:0] rj;
  logic [IDX_W-1:0] rank;
  logic             phase;

  logic signed [SAMPLE_W-1:0] med_lo;
  logic signed [SAMPLE_W-1:0] med_hi;
  logic signed [SAMPLE_W:0]   med2;

  logic signed [SUM_W-1:0] sum;
  logic [COUNT_W-1:0]      good;
  logic [STORE_N-1:0]      mask;
  logic [MEAN_W-1:0]       mean;
  logic                    have;

  logic               accept;
  logic               ok;
  logic               store_en;
  logic [COUNT_W-1:0] kept_next;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   lo_rank;
  logic [IDX_W-1:0]   hi_rank;
  logic               lt;
  logic [IDX_W-1:0]   rank_next;

  logic signed [SAMPLE_W:0]   a2;
  logic signed [SAMPLE_W+1:0] diff;
  logic [SAMPLE_W+1:0]        absd;
  logic                       outlier;

  logic              div_start;
  logic              div_done;
  logic [MEAN_W-1:0] div_q;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign done      = (state == S_DONE);

  assign result.mean_temp    = mean;
  assign result.mean_valid   = have;
  assign result.outlier_mask = mask;
  assign result.pass_count   = n;

  // validity test and store admission
  assign ok = item.sample_present && (item.sample > valid_low) &&
              (item.sample < valid_high) && (item.sample != '0) &&
              (item.sample != TEMP_85);
  assign store_en  = accept && ok && ({1'b0, position} < SENS_LIM) &&
                     !position[COUNT_W-1] && !kept_count[COUNT_W-1];
  assign kept_next = kept_count + COUNT_W'(store_en);

  assign last_idx = IDX_W'(n - 1'b1);
  assign lo_rank  = IDX_W'((n - 1'b1) >> 1);
  assign hi_rank  = IDX_W'(n >> 1);

  // rank compare, ties broken by store index
  assign lt        = (rd_b.sample < rd_a.sample) ||
                     ((rd_b.sample == rd_a.sample) && (rj < ri));
  assign rank_next = rank + IDX_W'(lt);

  // distance to median at 1/32 resolution
  assign a2      = {rd_a.sample, 1'b0};
  assign diff    = {a2[SAMPLE_W], a2} - {med2[SAMPLE_W], med2};
  assign absd    = diff[SAMPLE_W+1] ? (SAMPLE_W + 2)'(-diff) : diff;
  assign outlier = absd > {3'b000, threshold, 1'b0};

  assign div_start = (state == S_PREP) && (good != '0) && !sum[SUM_W-1];

  morm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum[DIVD_W-1:0]),
    .divisor  (good),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[kept_count[IDX_W-1:0]] <= '{sample: item.sample, origin: position[IDX_W-1:0]};
    end
    rd_a <= mem[ri];
    rd_b <= mem[rj];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      valid_low  <= VALID_LOW_RST;
      valid_high <= VALID_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data[THR_W-1:0];
        REG_VALID_LOW:  valid_low  <= cfg_data;
        REG_VALID_HIGH: valid_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      position   <= '0;
      kept_count <= '0;
      n          <= '0;
      ri         <= '0;
      rj         <= '0;
      rank       <= '0;
      phase      <= 1'b0;
      sum        <= '0;
      good       <= '0;
      mask       <= '0;
      mean       <= '0;
      have       <= 1'b0;
      med_lo     <= '0;
      med_hi     <= '0;
      med2       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.last_sample) begin
              n          <= kept_next;
              position   <= '0;
              kept_count <= '0;
              ri         <= '0;
              rj         <= '0;
              rank       <= '0;
              phase      <= 1'b0;
              sum        <= '0;
              good       <= '0;
              mask       <= '0;
              mean       <= '0;
              have       <= 1'b0;
              state      <= (kept_next == '0) ? S_DONE : S_RANK;
            end else begin
              kept_count <= kept_next;
              if (position != '1) begin
                position <= position + 1'b1;
              end
            end
          end
        end
        S_RANK: begin
          phase <= !phase;
          if (phase) begin
            if (rj == last_idx) begin
              if (rank_next == lo_rank) begin
                med_lo <= rd_a.sample;
              end
              if (rank_next == hi_rank) begin
                med_hi <= rd_a.sample;
              end
              rank <= '0;
              rj   <= '0;
              if (ri == last_idx) begin
                ri    <= '0;
                state <= S_SCAN;
              end else begin
                ri <= ri + 1'b1;
              end
            end else begin
              rank <= rank_next;
              rj   <= rj + 1'b1;
            end
          end
        end
        S_SCAN: begin
          phase <= !phase;
          if (!phase) begin
            med2 <= {med_lo[SAMPLE_W-1], med_lo} + {med_hi[SAMPLE_W-1], med_hi};
          end else begin
            if (outlier) begin
              mask[rd_a.origin] <= 1'b1;
            end else begin
              sum  <= sum + SUM_W'(rd_a.sample);
              good <= good + 1'b1;
            end
            if (ri == last_idx) begin
              state <= S_PREP;
            end else begin
              ri <= ri + 1'b1;
            end
          end
        end
        S_PREP: begin
          if (good == '0) begin
            state <= S_DONE;
          end else if (sum[SUM_W-1]) begin
            have  <= 1'b1;
            state <= S_DONE;
          end else begin
            have  <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= div_q;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/median_outlier_reject_mean_core_tb.sv]
module median_outlier_reject_mean_core_tb;
  import morm_pkg::*;

  localparam int SENSOR_N = 8;
  localparam int TAIL_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_READINGS = 440;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        idx;
    logic [SAMPLE_W-1:0] data;
    item_t             it;
    logic              pinned;
    result_t           want;
  } row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [1:0] cfg_index;
  logic [SAMPLE_W-1:0] cfg_data;

  // mirror of the block's registers and round state
  logic [THR_W-1:0]           thr_q;
  logic signed [SAMPLE_W-1:0] lo_q;
  logic signed [SAMPLE_W-1:0] hi_q;
  logic signed [SAMPLE_W-1:0] kept_val [STORE_N];
  logic [IDX_W-1:0]           kept_src [STORE_N];
  int                         pos_q;
  int                         kept_n;

  result_t round_results_due[$];
  row_t    dir_tab[$];
  logic    pin_on;
  result_t pin_want;

  int n_beats;
  int n_counted;
  int n_writes;
  int n_results;
  int n_outlier_rounds;
  int n_no_mean;
  int mismatches;

  median_outlier_reject_mean_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void screen_reading(item_t it);
    int s;
    bit ok;
    s = $signed(it.sample);
    ok = it.sample_present && s > int'(lo_q) && s < int'(hi_q) && s != 0 &&
         s != int'(TEMP_85);
    if (ok && pos_q < SENSOR_N && pos_q < STORE_N && kept_n < STORE_N) begin
      kept_val[kept_n] = it.sample;
      kept_src[kept_n] = pos_q[IDX_W-1:0];
      kept_n++;
    end
    if (pos_q < 15) pos_q++;
  endfunction

  function automatic result_t settle_round();
    int vals [STORE_N];
    int ord [STORE_N];
    int n, i, j, key, med2, lim, d, sum, good, mean;
    logic [STORE_N-1:0] mask;
    bit have;
    result_t r;
    n = kept_n;
    mask = '0;
    sum = 0;
    good = 0;
    mean = 0;
    have = 0;
    for (i = 0; i < STORE_N; i++) begin
      vals[i] = (i < n) ? int'(kept_val[i]) : 0;
      ord[i] = vals[i];
    end
    if (n == 1) begin
      mean = vals[0];
      have = 1;
    end else if (n >= 2) begin
      lim = 2 * int'(thr_q);
      for (i = 1; i < n; i++) begin
        key = ord[i];
        j = i;
        while (j > 0 && ord[j-1] > key) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = key;
      end
      med2 = (n % 2) ? 2 * ord[n/2] : ord[n/2-1] + ord[n/2];
      for (i = 0; i < n; i++) begin
        d = 2 * vals[i] - med2;
        if (d < 0) d = -d;
        if (d > lim) begin
          mask[kept_src[i]] = 1'b1;
        end else begin
          sum += vals[i];
          good++;
        end
      end
      if (good > 0) begin
        mean = sum / good;
        have = 1;
      end
    end
    if (mean < 0) mean = 0;
    if (!have) mean = 0;
    r.mean_temp = mean[MEAN_W-1:0];
    r.mean_valid = have;
    r.outlier_mask = mask;
    r.pass_count = n[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void store_setting(logic [1:0] idx, logic [SAMPLE_W-1:0] data);
    case (idx)
      REG_THRESHOLD:  thr_q = data[THR_W-1:0];
      REG_VALID_LOW:  lo_q = data;
      REG_VALID_HIGH: hi_q = data;
      default: ;
    endcase
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (round_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: mean %0d valid %0b mask %02h count %0d",
                 got.mean_temp, got.mean_valid, got.outlier_mask, got.pass_count);
      return;
    end
    want = round_results_due.pop_front();
    n_results++;
    if (want.outlier_mask != 0) n_outlier_rounds++;
    if (!want.mean_valid) n_no_mean++;
    if (got.mean_temp !== want.mean_temp || got.mean_valid !== want.mean_valid ||
        got.outlier_mask !== want.outlier_mask || got.pass_count !== want.pass_count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: expected mean %0d valid %0b mask %02h count %0d",
                 n_results, want.mean_temp, want.mean_valid, want.outlier_mask,
                 want.pass_count);
        $display("result %0d: got mean %0d valid %0b mask %02h count %0d",
                 n_results, got.mean_temp, got.mean_valid, got.outlier_mask,
                 got.pass_count);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_result(result);
      if (start && !busy) begin
        n_beats++;
        screen_reading(item);
        if (item.last_sample) begin
          round_results_due.push_back(pin_on ? pin_want : settle_round());
          pos_q = 0;
          kept_n = 0;
        end
      end
    end
  end

  task automatic send_item(item_t it, int pct, logic pin, result_t want);
    @(negedge clk);
    while (int'($urandom_range(0, 99)) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    pin_on = pin;
    pin_want = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (round_results_due.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [SAMPLE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    store_setting(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic new_settings();
    int lo, hi, thr;
    case ($urandom_range(0, 9))
      0: begin
        lo = -880;
        hi = 2000;
        thr = 0;
      end
      1: begin
        lo = -880;
        hi = 2000;
        thr = 1023;
      end
      2: begin
        // crossed limits
        lo = int'($urandom_range(0, 2880)) - 880;
        hi = lo - int'($urandom_range(0, 200));
        thr = $urandom_range(0, 1023);
      end
      3: begin
        lo = -880 + int'($urandom_range(0, 800));
        hi = lo + int'($urandom_range(300, 1200));
        thr = $urandom_range(0, 4095);
      end
      default: begin
        lo = -880 + int'($urandom_range(0, 1600));
        hi = lo + int'($urandom_range(100, 1500));
        if (hi > 2000) hi = 2000;
        thr = $urandom_range(0, 300);
      end
    endcase
    write_reg(REG_THRESHOLD, thr[SAMPLE_W-1:0]);
    write_reg(REG_VALID_LOW, lo[SAMPLE_W-1:0]);
    write_reg(REG_VALID_HIGH, hi[SAMPLE_W-1:0]);
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, SAMPLE_W'($urandom_range(0, 4095)));
  endtask

  task automatic send_round(int len, int pct);
    int centre, spread, i, v, lo, hi, roll;
    logic present;
    item_t it;
    lo = lo_q;
    hi = hi_q;
    if (hi > lo + 1) centre = lo + 1 + int'($urandom_range(0, hi - lo - 2));
    else centre = int'($urandom_range(0, 2880)) - 880;
    spread = $urandom_range(0, int'(thr_q) + 40);
    for (i = 0; i < len; i++) begin
      present = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        present = 1'b0;
        v = $urandom_range(0, 4095);
      end else if (roll < 14) begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = int'(TEMP_85);
          2: v = lo;
          3: v = hi;
          4: v = lo + 1;
          5: v = hi - 1;
          6: v = -2048;
          default: v = 2047;
        endcase
      end else if (roll < 20) begin
        v = $urandom_range(0, 4095);
      end else begin
        v = centre - spread + int'($urandom_range(0, 2 * spread));
      end
      it.sample = v[SAMPLE_W-1:0];
      it.sample_present = present;
      it.last_sample = (i == len - 1);
      send_item(it, pct, 1'b0, '0);
      n_counted++;
    end
  endtask

  function automatic row_t item_row(int s, logic p, logic l);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.it.sample = s[SAMPLE_W-1:0];
    r.it.sample_present = p;
    r.it.last_sample = l;
    return r;
  endfunction

  function automatic row_t pinned_row(int s, logic p, int m, logic v, int mask, int cnt);
    row_t r;
    r = item_row(s, p, 1'b1);
    r.pinned = 1'b1;
    r.want.mean_temp = m[MEAN_W-1:0];
    r.want.mean_valid = v;
    r.want.outlier_mask = mask[STORE_N-1:0];
    r.want.pass_count = cnt[COUNT_W-1:0];
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, int d);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = d[SAMPLE_W-1:0];
    return r;
  endfunction

  initial begin
    int ph, pct, len, left_in_setting, phase_base, k;
    row_t row;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_on = 1'b0;
    pin_want = '0;
    thr_q = THRESHOLD_RST;
    lo_q = VALID_LOW_RST;
    hi_q = VALID_HIGH_RST;
    pos_q = 0;
    kept_n = 0;
    for (k = 0; k < STORE_N; k++) begin
      kept_val[k] = '0;
      kept_src[k] = '0;
    end
    n_beats = 0;
    n_counted = 0;
    n_writes = 0;
    n_results = 0;
    n_outlier_rounds = 0;
    n_no_mean = 0;
    mismatches = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // missing reading only, then a single reading at reset limits
    dir_tab.push_back(pinned_row(0, 1'b0, 0, 1'b0, 0, 0));
    dir_tab.push_back(pinned_row(500, 1'b1, 500, 1'b1, 0, 1));
    dir_tab.push_back(cfg_row(REG_VALID_LOW, -880));
    dir_tab.push_back(cfg_row(REG_VALID_HIGH, 2000));
    // exact zero, exact 85 degrees and both limits are rejected
    dir_tab.push_back(item_row(0, 1'b1, 1'b0));
    dir_tab.push_back(item_row(1360, 1'b1, 1'b0));
    dir_tab.push_back(item_row(-880, 1'b1, 1'b0));
    dir_tab.push_back(item_row(2000, 1'b1, 1'b0));
    dir_tab.push_back(pinned_row(1, 1'b1, 1, 1'b1, 0, 1));
    // negative mean clamps to zero
    dir_tab.push_back(pinned_row(-500, 1'b1, 0, 1'b1, 0, 1));
    dir_tab.push_back(cfg_row(REG_THRESHOLD, 0));
    dir_tab.push_back(item_row(100, 1'b1, 1'b0));
    dir_tab.push_back(item_row(100, 1'b1, 1'b0));
    dir_tab.push_back(item_row(100, 1'b1, 1'b0));
    dir_tab.push_back(pinned_row(900, 1'b1, 100, 1'b1, 8'h08, 4));
    // every reading excluded
    dir_tab.push_back(item_row(100, 1'b1, 1'b0));
    dir_tab.push_back(pinned_row(300, 1'b1, 0, 1'b0, 8'h03, 2));
    // crossed limits
    dir_tab.push_back(cfg_row(REG_VALID_LOW, 500));
    dir_tab.push_back(cfg_row(REG_VALID_HIGH, 400));
    dir_tab.push_back(pinned_row(450, 1'b1, 0, 1'b0, 0, 0));
    dir_tab.push_back(cfg_row(REG_VALID_LOW, -880));
    dir_tab.push_back(cfg_row(REG_VALID_HIGH, 2000));
    dir_tab.push_back(cfg_row(REG_THRESHOLD, 1023));
    dir_tab.push_back(cfg_row(REG_NONE, 0));
    // overlong round, sensors past the eighth ignored
    dir_tab.push_back(item_row(2047, 1'b1, 1'b0));
    dir_tab.push_back(item_row(-2048, 1'b1, 1'b0));
    dir_tab.push_back(item_row(700, 1'b1, 1'b0));
    dir_tab.push_back(item_row(710, 1'b1, 1'b0));
    dir_tab.push_back(item_row(1990, 1'b1, 1'b0));
    dir_tab.push_back(item_row(-870, 1'b1, 1'b0));
    dir_tab.push_back(item_row(0, 1'b1, 1'b0));
    dir_tab.push_back(item_row(650, 1'b1, 1'b0));
    dir_tab.push_back(item_row(800, 1'b1, 1'b0));
    dir_tab.push_back(item_row(900, 1'b1, 1'b1));

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.it, 15, row.pinned, row.want);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 15 : (ph == 1) ? 56 : 0;
      left_in_setting = 0;
      phase_base = n_counted;
      while (n_counted - phase_base < PHASE_READINGS) begin
        if (left_in_setting == 0) begin
          drain();
          new_settings();
          left_in_setting = $urandom_range(3, 10);
        end
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 20))
                                          : int'($urandom_range(1, 8));
        send_round(len, pct);
        left_in_setting--;
        if ($urandom_range(0, 11) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (round_results_due.size() != 0) begin
      $display("%0d results never arrived", round_results_due.size());
      mismatches += round_results_due.size();
    end
    $display("%0d readings in %0d rounds over %0d register writes",
             n_beats, n_results, n_writes);
    $display("%0d rounds with outliers, %0d without a mean, %0d mismatching or unexpected",
             n_outlier_rounds, n_no_mean, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
